// ----- rtl/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package bmf_pkg;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Field widths fixed by the interface.
  localparam int CFG_DATA_W = 16;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int MEAN_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int PIXEL_W    = 8;

  // Register values after reset.
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/bmf_pix_if.sv -----
// ----------------------------------------------------------------------------
// bmf_pix_if: input pixel channel
// Valid/ready channel carrying one pixel per transfer.
// ----------------------------------------------------------------------------
interface bmf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/bmf_res_if.sv -----
// ----------------------------------------------------------------------------
// bmf_res_if: result channel
// Valid/ready channel carrying one window mean per transfer.
// ----------------------------------------------------------------------------
interface bmf_res_if;
  logic                         valid;
  logic                         ready;
  logic [bmf_pkg::ROW_W-1:0]     out_row;
  logic [bmf_pkg::OUT_COL_W-1:0] out_col;
  logic [bmf_pkg::MEAN_W-1:0]    mean;
  logic [bmf_pkg::COUNT_W-1:0]   window_count;
  logic                         last_of_run;

  modport source (output valid, output out_row, output out_col, output mean,
                  output window_count, output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input mean,
                  input window_count, input last_of_run, output ready);
endinterface

// ----- rtl/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 5120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, or read into the registered output.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ----- rtl/bmf_div.sv -----
// ----------------------------------------------------------------------------
// bmf_div: restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
module bmf_div #(
  parameter int DW = 30,
  parameter int NW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [NW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [NW-1:0]    div_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NW:0]      trial;

  // One restoring step per cycle.
  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = NW'(trial - {1'b0, div_q});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[NW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/box_mean_filter_5x5.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter_5x5: clipped box mean over a square window
// Channel   Dir  Payload
// pix_i     in   pixel (8b)
// res_o     out  out_row, out_col, mean (Q8.8), window_count, last_of_run
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (width, height)
//
// Each pixel is stored in the idle state; pix_i is not ready again until every
// result it completes has been transferred. The window is summed one line store
// read per cycle, then divided one bit per cycle by a DW-bit divider, DW = 22
// at the defaults. The line store has no clearing pass.
// Back-pressure on res_o holds the sequencer in place.
// ----------------------------------------------------------------------------
module box_mean_filter_5x5 #(
  parameter int MAX_WIDTH     = 1024,
  parameter int WINDOW_RADIUS = 2,
  parameter int PIXEL_BITS    = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bmf_pix_if.sink                        pix_i,
  bmf_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LINES = 2 * WINDOW_RADIUS + 1;
  localparam int DEPTH = LINES * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = $clog2(LINES);
  localparam int RW    = bmf_pkg::ROW_W;
  localparam int NW    = $clog2(LINES * LINES + 1);
  localparam int SW    = PIXEL_BITS + NW;
  localparam int DW    = SW + 9;

  localparam logic [RW-1:0] RAD_R = RW'(WINDOW_RADIUS);
  localparam logic [CW-1:0] RAD_C = CW'(WINDOW_RADIUS);

  // Configuration registers.
  logic [10:0]   width_q;
  logic [RW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmf_pkg::WIDTH_RESET;
      height_q <= bmf_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmf_pkg::REG_WIDTH:  width_q  <= cfg_data_i[10:0];
        bmf_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, as last index values.
  logic [WW-1:0] eff_w;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    w_last = CW'(eff_w - 1'b1);
    h_last = (height_q == '0) ? '0 : height_q - 1'b1;
  end

  // Sequencer registers.
  bmf_pkg::state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] rline_q, rline_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [LW-1:0] cur_line_q, cur_line_d;
  logic [RW-1:0] y_q, y_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic [CW-1:0] x_q, x_d, xlo_q, xlo_d, xhi_q, xhi_d;
  logic [RW-1:0] i_q, i_d, r1_q, r1_d;
  logic [CW-1:0] j_q, j_d, c0_q, c0_d, c1_q, c1_d;
  logic [LW-1:0] li_q, li_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [NW-1:0] n_q, n_d;
  logic          rd_vld_q, rd_vld_d;
  logic [bmf_pkg::MEAN_W-1:0] mean_q, mean_d;

  // Memory and divider connections.
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [PIXEL_BITS-1:0] mem_rdata;
  logic                  div_start, div_done;
  logic [DW-1:0]         div_quo;
  logic [DW-1:0]         dividend;

  // Scratch values of the sequencer.
  logic          restart;
  logic [RW-1:0] r_eff;
  logic [CW-1:0] c_eff;
  logic [LW-1:0] line_eff;
  logic [RW:0]   r1_wide;
  logic [CW:0]   c1_wide;
  logic [RW-1:0] r0_v, r1_v, d_v;
  logic [CW-1:0] c0_v, c1_v;
  logic          rows_ok, cols_ok;

  assign dividend = {sum_q, 8'b0} + DW'(n_q >> 1);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    rline_d    = rline_q;
    cur_row_d  = cur_row_q;
    cur_line_d = cur_line_q;
    y_d = y_q;  ylo_d = ylo_q;  yhi_d = yhi_q;
    x_d = x_q;  xlo_d = xlo_q;  xhi_d = xhi_q;
    i_d = i_q;  r1_d = r1_q;
    j_d = j_q;  c0_d = c0_q;  c1_d = c1_q;
    li_d     = li_q;
    sum_d    = sum_q;
    n_d      = n_q;
    mean_d   = mean_q;
    rd_vld_d = 1'b0;
    mem_we   = 1'b0;
    mem_addr = '0;
    div_start   = 1'b0;
    pix_i.ready = 1'b0;
    res_o.valid = 1'b0;
    restart  = (row_q > h_last) || (col_q > w_last);
    r_eff    = restart ? '0 : row_q;
    c_eff    = restart ? '0 : col_q;
    line_eff = restart ? '0 : rline_q;
    rows_ok  = 1'b0;
    cols_ok  = 1'b0;
    r0_v = '0; r1_v = '0; c0_v = '0; c1_v = '0; d_v = '0;
    r1_wide = '0; c1_wide = '0;

    unique case (state_q)
      // Store the pixel and work out which windows it completes.
      bmf_pkg::ST_IDLE: begin
        pix_i.ready = 1'b1;
        mem_addr    = AW'(line_eff) * AW'(MAX_WIDTH) + AW'(c_eff);
        if (pix_i.valid) begin
          mem_we     = 1'b1;
          cur_row_d  = r_eff;
          cur_line_d = line_eff;
          if (r_eff == h_last) begin
            rows_ok = 1'b1;
            ylo_d   = (r_eff >= RAD_R) ? r_eff - RAD_R : '0;
            yhi_d   = r_eff;
          end else if (r_eff >= RAD_R) begin
            rows_ok = 1'b1;
            ylo_d   = r_eff - RAD_R;
            yhi_d   = r_eff - RAD_R;
          end
          if (c_eff == w_last) begin
            cols_ok = 1'b1;
            xlo_d   = (c_eff >= RAD_C) ? c_eff - RAD_C : '0;
            xhi_d   = c_eff;
          end else if (c_eff >= RAD_C) begin
            cols_ok = 1'b1;
            xlo_d   = c_eff - RAD_C;
            xhi_d   = c_eff - RAD_C;
          end
          y_d = ylo_d;
          x_d = xlo_d;
          if (rows_ok && cols_ok) begin
            state_d = bmf_pkg::ST_SETUP;
          end
          // Advance the raster position.
          if (c_eff == w_last) begin
            col_d = '0;
            if (r_eff == h_last) begin
              row_d   = '0;
              rline_d = '0;
            end else begin
              row_d   = r_eff + 1'b1;
              rline_d = (line_eff == LW'(LINES - 1)) ? '0 : line_eff + 1'b1;
            end
          end else begin
            col_d   = c_eff + 1'b1;
            row_d   = r_eff;
            rline_d = line_eff;
          end
        end
      end
      // Clip the window of the current centre and set up the read sweep.
      bmf_pkg::ST_SETUP: begin
        r0_v    = (y_q >= RAD_R) ? y_q - RAD_R : '0;
        r1_wide = {1'b0, y_q} + {1'b0, RAD_R};
        r1_v    = (r1_wide > {1'b0, h_last}) ? h_last : r1_wide[RW-1:0];
        c0_v    = (x_q >= RAD_C) ? x_q - RAD_C : '0;
        c1_wide = {1'b0, x_q} + {1'b0, RAD_C};
        c1_v    = (c1_wide > {1'b0, w_last}) ? w_last : c1_wide[CW-1:0];
        d_v     = cur_row_q - r0_v;
        li_d    = (cur_line_q >= LW'(d_v)) ? cur_line_q - LW'(d_v)
                                           : LW'(LINES) + cur_line_q - LW'(d_v);
        i_d   = r0_v;
        r1_d  = r1_v;
        j_d   = c0_v;
        c0_d  = c0_v;
        c1_d  = c1_v;
        sum_d = '0;
        n_d   = NW'(NW'(r1_v - r0_v + 1'b1) * NW'(c1_v - c0_v + 1'b1));
        state_d = bmf_pkg::ST_READ;
      end
      // One line store read per cycle; its data is summed in the cycle after the read.
      bmf_pkg::ST_READ: begin
        mem_addr = AW'(li_q) * AW'(MAX_WIDTH) + AW'(j_q);
        rd_vld_d = 1'b1;
        if (rd_vld_q) begin
          sum_d = sum_q + SW'(mem_rdata);
        end
        if (j_q == c1_q) begin
          j_d = c0_q;
          if (i_q == r1_q) begin
            state_d = bmf_pkg::ST_DRAIN;
          end else begin
            i_d  = i_q + 1'b1;
            li_d = (li_q == LW'(LINES - 1)) ? '0 : li_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      // Add the final read.
      bmf_pkg::ST_DRAIN: begin
        sum_d   = sum_q + SW'(mem_rdata);
        state_d = bmf_pkg::ST_DSTART;
      end
      bmf_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_d   = bmf_pkg::ST_DIV;
      end
      // Wait for the quotient and saturate it.
      bmf_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_quo > DW'({bmf_pkg::MEAN_W{1'b1}})) begin
            mean_d = '1;
          end else begin
            mean_d = div_quo[bmf_pkg::MEAN_W-1:0];
          end
          state_d = bmf_pkg::ST_OUT;
        end
      end
      // Hold the result until its transfer, then move to the next centre.
      bmf_pkg::ST_OUT: begin
        res_o.valid = 1'b1;
        if (res_o.ready) begin
          if (x_q == xhi_q) begin
            x_d = xlo_q;
            if (y_q == yhi_q) begin
              state_d = bmf_pkg::ST_IDLE;
            end else begin
              y_d     = y_q + 1'b1;
              state_d = bmf_pkg::ST_SETUP;
            end
          end else begin
            x_d     = x_q + 1'b1;
            state_d = bmf_pkg::ST_SETUP;
          end
        end
      end
      default: state_d = bmf_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bmf_pkg::ST_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      rline_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      rline_q  <= rline_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cur_row_q  <= cur_row_d;
    cur_line_q <= cur_line_d;
    y_q <= y_d;  ylo_q <= ylo_d;  yhi_q <= yhi_d;
    x_q <= x_d;  xlo_q <= xlo_d;  xhi_q <= xhi_d;
    i_q <= i_d;  r1_q <= r1_d;
    j_q <= j_d;  c0_q <= c0_d;  c1_q <= c1_d;
    li_q   <= li_d;
    sum_q  <= sum_d;
    n_q    <= n_d;
    mean_q <= mean_d;
  end

  // Line store.
  bmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (PIXEL_BITS'(pix_i.pixel)),
    .rdata_o (mem_rdata)
  );

  // Mean divider.
  bmf_div #(
    .DW (DW),
    .NW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Result payload.
  assign res_o.out_row      = y_q;
  assign res_o.out_col      = bmf_pkg::OUT_COL_W'(x_q);
  assign res_o.mean         = mean_q;
  assign res_o.window_count = bmf_pkg::COUNT_W'(n_q);
  assign res_o.last_of_run  = (x_q == xhi_q) && (y_q == yhi_q);

endmodule
